// ===== rtl/rtac_pkg.sv =====
// Package with payload types, status codes and the CORDIC angle table.
`timescale 1ns / 1ps
`default_nettype none
package rtac_pkg;

  localparam int unsigned SideBits        = 16;
  localparam int unsigned AngleFracBits   = 8;
  localparam int unsigned ArcsinIterations = 16;
  localparam int unsigned AccFrac         = 24;
  localparam int unsigned AngleOutBits    = 15;
  localparam int unsigned TableLen        = 32;

  typedef enum logic [1:0] {
    STATUS_RIGHT      = 2'd0,
    STATUS_NOT_RIGHT  = 2'd1,
    STATUS_DEGENERATE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [SideBits-1:0] side_a;
    logic signed [SideBits-1:0] side_b;
    logic signed [SideBits-1:0] side_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [AngleOutBits-1:0] angle_alpha;
    logic [AngleOutBits-1:0] angle_beta;
    logic [2:0]              fixed_sides;
  } out_item_t;

  // Rotation angles atan(2^-i) in degrees, Q.24.
  function automatic logic [31:0] atan_deg_q24(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489088;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509720;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      5'd24: r = 32'd57;
      5'd25: r = 32'd29;
      5'd26: r = 32'd14;
      5'd27: r = 32'd7;
      5'd28: r = 32'd4;
      5'd29: r = 32'd2;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rtac_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation, for both angles in parallel.
`timescale 1ns / 1ps
`default_nettype none
module rtac_cordic_stage #(
  parameter int unsigned VecBits = 48,
  parameter int unsigned Shift   = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic signed [VecBits-1:0] ax_i,
  input  wire logic signed [VecBits-1:0] ay_i,
  input  wire logic signed [31:0]        az_i,
  input  wire logic signed [VecBits-1:0] bx_i,
  input  wire logic signed [VecBits-1:0] by_i,
  input  wire logic signed [31:0]        bz_i,
  output logic signed [VecBits-1:0]      ax_o,
  output logic signed [VecBits-1:0]      ay_o,
  output logic signed [31:0]             az_o,
  output logic signed [VecBits-1:0]      bx_o,
  output logic signed [VecBits-1:0]      by_o,
  output logic signed [31:0]             bz_o
);
  import rtac_pkg::*;

  logic signed [31:0] t;
  logic signed [VecBits-1:0] ax_d, ay_d, bx_d, by_d;
  logic signed [31:0] az_d, bz_d;

  assign t = $signed(atan_deg_q24(5'(Shift)));

  always_comb begin
    if (!ay_i[VecBits-1]) begin
      ax_d = ax_i + (ay_i >>> Shift);
      ay_d = ay_i - (ax_i >>> Shift);
      az_d = az_i + t;
    end else begin
      ax_d = ax_i - (ay_i >>> Shift);
      ay_d = ay_i + (ax_i >>> Shift);
      az_d = az_i - t;
    end
    if (!by_i[VecBits-1]) begin
      bx_d = bx_i + (by_i >>> Shift);
      by_d = by_i - (bx_i >>> Shift);
      bz_d = bz_i + t;
    end else begin
      bx_d = bx_i - (by_i >>> Shift);
      by_d = by_i + (bx_i >>> Shift);
      bz_d = bz_i - t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_o <= ax_d;
      ay_o <= ay_d;
      az_o <= az_d;
      bx_o <= bx_d;
      by_o <= by_d;
      bz_o <= bz_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/right_triangle_angle_calc_unit.sv =====
// Top level of the right-triangle angle unit: side check and CORDIC pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one triangle per cycle and returns one result per triangle, in order.
// The stages are, in order: one for side magnitudes, one for the squares, one
// for the sum compare and CORDIC seed, one per CORDIC micro-rotation, and one
// for clamping and rounding into the output register.
// The whole pipeline advances when the output register is empty or being read,
// so a stalled consumer holds every stage in place. Rate is one item per cycle.
module right_triangle_angle_calc_unit #(
  parameter int unsigned ARCSIN_ITERATIONS = rtac_pkg::ArcsinIterations
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire rtac_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rtac_pkg::out_item_t      out_data_o
);
  import rtac_pkg::*;

  localparam int unsigned NIter   = (ARCSIN_ITERATIONS > TableLen) ? TableLen
                                                                  : ARCSIN_ITERATIONS;
  localparam int unsigned MagBits = SideBits;
  localparam int unsigned VecBits = MagBits + AccFrac + 2;
  localparam int unsigned Sh      = AccFrac - AngleFracBits;
  localparam int unsigned Stages  = NIter + 4;

  logic adv;
  logic [Stages-1:0] vld_q;

  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Stages-1];

  // Stage 1: magnitudes.
  logic [MagBits-1:0] a1_q, b1_q, c1_q;
  logic [2:0] neg1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q <= in_data_i.side_a[SideBits-1] ? MagBits'(-in_data_i.side_a)
                                           : MagBits'(in_data_i.side_a);
      b1_q <= in_data_i.side_b[SideBits-1] ? MagBits'(-in_data_i.side_b)
                                           : MagBits'(in_data_i.side_b);
      c1_q <= in_data_i.side_c[SideBits-1] ? MagBits'(-in_data_i.side_c)
                                           : MagBits'(in_data_i.side_c);
      neg1_q <= {in_data_i.side_c[SideBits-1], in_data_i.side_b[SideBits-1],
                 in_data_i.side_a[SideBits-1]};
    end
  end

  // Stage 2: squares. The most negative code gives magnitude 2^(SideBits-1),
  // which fits in MagBits unsigned bits.
  logic [2*MagBits-1:0] aa2_q, bb2_q, cc2_q;
  logic [MagBits-1:0] a2_q, b2_q;
  logic [2:0] neg2_q;
  logic zero2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      aa2_q <= a1_q * a1_q;
      bb2_q <= b1_q * b1_q;
      cc2_q <= c1_q * c1_q;
      a2_q <= a1_q;
      b2_q <= b1_q;
      neg2_q <= neg1_q;
      zero2_q <= (a1_q == '0) && (b1_q == '0) && (c1_q == '0);
    end
  end

  // Stage 3: exact compare and CORDIC seed.
  logic [1:0] st_q [3:Stages-1];
  logic [2:0] neg_q [3:Stages-1];
  logic signed [VecBits-1:0] ax [3:Stages-1];
  logic signed [VecBits-1:0] ay [3:Stages-1];
  logic signed [VecBits-1:0] bx [3:Stages-1];
  logic signed [VecBits-1:0] by [3:Stages-1];
  logic signed [31:0] az [3:Stages-1];
  logic signed [31:0] bz [3:Stages-1];
  logic [2*MagBits:0] sum2;
  assign sum2 = {1'b0, aa2_q} + {1'b0, bb2_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (zero2_q) begin
        st_q[3] <= STATUS_DEGENERATE;
      end else if (sum2 == {1'b0, cc2_q}) begin
        st_q[3] <= STATUS_RIGHT;
      end else begin
        st_q[3] <= STATUS_NOT_RIGHT;
      end
      neg_q[3] <= neg2_q;
      ax[3] <= $signed({2'b00, b2_q, AccFrac'(0)});
      ay[3] <= $signed({2'b00, a2_q, AccFrac'(0)});
      bx[3] <= $signed({2'b00, a2_q, AccFrac'(0)});
      by[3] <= $signed({2'b00, b2_q, AccFrac'(0)});
      az[3] <= '0;
      bz[3] <= '0;
    end
  end

  for (genvar i = 0; i < NIter; i++) begin : g_rot
    rtac_cordic_stage #(
      .VecBits(VecBits),
      .Shift  (i)
    ) u_stage (
      .clk_i(clk_i),
      .en_i (adv),
      .ax_i (ax[3+i]),
      .ay_i (ay[3+i]),
      .az_i (az[3+i]),
      .bx_i (bx[3+i]),
      .by_i (by[3+i]),
      .bz_i (bz[3+i]),
      .ax_o (ax[4+i]),
      .ay_o (ay[4+i]),
      .az_o (az[4+i]),
      .bx_o (bx[4+i]),
      .by_o (by[4+i]),
      .bz_o (bz[4+i])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[4+i] <= st_q[3+i];
        neg_q[4+i] <= neg_q[3+i];
      end
    end
  end

  // Final stage: clamp, round half up, mask.
  function automatic logic [AngleOutBits-1:0] finish(input logic signed [31:0] z);
    logic signed [31:0] c;
    logic [31:0] r;
    c = z;
    if (z < 0) c = '0;
    if (z > 32'sd1509949440) c = 32'sd1509949440;
    r = (32'(c) + (32'd1 << (Sh - 1))) >> Sh;
    return r[AngleOutBits-1:0];
  endfunction

  localparam int unsigned L = Stages - 1;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.status <= st_q[L];
      out_data_o.fixed_sides <= neg_q[L];
      out_data_o.angle_alpha <= (st_q[L] == STATUS_RIGHT) ? finish(az[L]) : '0;
      out_data_o.angle_beta <= (st_q[L] == STATUS_RIGHT) ? finish(bz[L]) : '0;
    end
  end

endmodule
`default_nettype wire
